// File: sv/tts_pkg.sv
// tts_pkg: shared types and constants for the task timer table scheduler.
// No dependencies; imported by tts_slot_alu and task_timer_table_scheduler_unit.
package tts_pkg;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_PROC,
    ST_FLUSH
  } state_e;

  localparam logic       KIND_ADD    = 1'b0;
  localparam logic       KIND_RUN    = 1'b1;
  localparam int         MAX_RESULTS = 16;
  localparam int         NW          = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0] PENDING_MAX = 8'hFF;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } slot_rec_t;

  // Status from the slot update unit.
  typedef struct packed {
    logic emit;   // slot has a run to hand out
    logic free;   // one-shot slot, release after this run
  } alu_stat_t;

endpackage

// File: sv/tts_if.sv
// tts_in_if / tts_out_if: valid-ready channels of the scheduler.
// Payload widths follow the fixed item fields; no package needed.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] task_handle;
  logic [31:0] delay_ticks;
  logic [31:0] period_ticks;
  logic [3:0]  target_slot;

  modport source (output valid, action, task_handle, delay_ticks, period_ticks,
                  target_slot, input ready);
  modport sink   (input valid, action, task_handle, delay_ticks, period_ticks,
                  target_slot, output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [4:0]  slot_index;
  logic [15:0] run_handle;
  logic        last_of_run;

  modport source (output valid, result_kind, slot_index, run_handle, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, slot_index, run_handle, last_of_run,
                  output ready);
endinterface

// File: sv/tts_ram.sv
// tts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/tts_slot_alu.sv
// tts_slot_alu: shared slot update unit (delay countdown, pending count).
// Depends on tts_pkg.
module tts_slot_alu
  import tts_pkg::*;
(
  input  action_e   op_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o,
  output alu_stat_t stat_o
);
  logic [31:0] dec;
  logic        due;

  always_comb begin
    dec    = rec_i.delay - 32'd1;
    due    = (rec_i.delay == 32'd0) || (dec == 32'd0);
    rec_o  = rec_i;
    stat_o = '0;
    case (op_i)
      ACT_TICK: begin
        if (rec_i.delay != 32'd0) begin
          rec_o.delay = dec;
        end
        if (due) begin
          if (rec_i.pending != PENDING_MAX) begin
            rec_o.pending = rec_i.pending + 8'd1;
          end
          if (rec_i.period != 32'd0) begin
            rec_o.delay = rec_i.period;
          end
        end
      end
      ACT_DISPATCH: begin
        if (rec_i.pending != 8'd0) begin
          stat_o.emit   = 1'b1;
          stat_o.free   = (rec_i.period == 32'd0);
          rec_o.pending = rec_i.pending - 8'd1;
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end
endmodule

// File: sv/task_timer_table_scheduler_unit.sv
// task_timer_table_scheduler_unit: table of timed task slots with add,
// delete, tick and dispatch. Depends on tts_pkg, tts_if, tts_ram, tts_slot_alu.
//
//  channel | dir | beat carries
//  --------+-----+-----------------------------------------------------------
//  in_i    | in  | action, task_handle, delay_ticks, period_ticks, target_slot
//  out_o   | out | result_kind, slot_index, run_handle, last_of_run
//
// Sequencing: delete finishes in the idle state; add walks the valid bits one
//   slot a cycle until a free slot or the last slot; tick and dispatch
//   read-modify-write each slot through the slot RAM at one shared address,
//   and a dispatch ends in a flush state that hands out its last beat.
// Reset: valid bits clear at once; slot RAM is never cleared, free slots are
//   rewritten in full on add.
// Stalls: in_i.ready is high only between items; out_o backpressure holds the
//   end of an add and the next dispatch run beat while a result waits in the output register.
module task_timer_table_scheduler_unit
  import tts_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tts_in_if.sink    in_i,
  tts_out_if.source out_o
);
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // Sequencer state
  state_e           state_q, state_d;
  action_e          op_q;
  logic [CW-1:0]    cnt_q;
  logic [NW-1:0]    n_q;
  logic [NUM_SLOTS-1:0] used_q, used_d;

  // Captured add payload
  logic [15:0]      handle_q;
  logic [31:0]      delay_q, period_q;

  // Lookahead beat: held until we know whether it is the last of a dispatch
  logic             held_valid_q;
  logic [CW-1:0]    held_slot_q;
  logic [15:0]      held_handle_q;

  // Output register
  logic             out_valid_q;
  logic             out_kind_q, out_last_q;
  logic [CW-1:0]    out_slot_q;
  logic [15:0]      out_handle_q;

  // Slot RAM and update unit
  slot_rec_t        rd_rec, alu_rec, wr_rec;
  alu_stat_t        alu_stat;
  logic             ram_we;
  logic [IW-1:0]    addr;

  // Control strobes
  logic             in_acc, out_free, last_slot, cur_used;
  logic             scan_hit, emit_go, stall, n_full;
  logic [CW+3:0]    tgt_wide;
  logic [CW+4:0]    slot_wide;

  assign in_acc    = in_i.valid & in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign addr      = cnt_q[IW-1:0];
  assign last_slot = (cnt_q == CW'(NUM_SLOTS - 1));
  assign cur_used  = used_q[addr];
  assign scan_hit  = !cur_used;
  assign emit_go   = (op_q == ACT_DISPATCH) && cur_used && alu_stat.emit;
  assign stall     = emit_go && held_valid_q && !out_free;
  assign n_full    = (n_q == NW'(MAX_RESULTS - 1));
  assign tgt_wide  = (CW+4)'(in_i.target_slot);

  tts_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (wr_rec),
    .raddr_i (addr),
    .rdata_o (rd_rec)
  );

  tts_slot_alu u_alu (
    .op_i   (op_q),
    .rec_i  (rd_rec),
    .rec_o  (alu_rec),
    .stat_o (alu_stat)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_e'(in_i.action))
            ACT_ADD:    state_d = ST_SCAN;
            ACT_DELETE: state_d = ST_IDLE;
            default:    state_d = ST_READ;
          endcase
        end
      end
      ST_SCAN: begin
        if ((scan_hit || last_slot) && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_PROC;
      ST_PROC: begin
        if (!stall) begin
          if (emit_go && n_full) begin
            state_d = ST_FLUSH;
          end else if (last_slot) begin
            state_d = (op_q == ACT_DISPATCH) ? ST_FLUSH : ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!held_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM write and valid-bit updates
  always_comb begin
    ram_we = 1'b0;
    wr_rec = alu_rec;
    used_d = used_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_e'(in_i.action) == ACT_DELETE)
            && (tgt_wide < (CW+4)'(NUM_SLOTS))) begin
          used_d[tgt_wide[IW-1:0]] = 1'b0;
        end
      end
      ST_SCAN: begin
        wr_rec = '{handle: handle_q, delay: delay_q, period: period_q, pending: 8'd0};
        if (scan_hit && out_free) begin
          ram_we       = 1'b1;
          used_d[addr] = 1'b1;
        end
      end
      ST_PROC: begin
        ram_we = !stall;
        if (emit_go && !stall && alu_stat.free) begin
          used_d[addr] = 1'b0;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= ACT_ADD;
      cnt_q        <= '0;
      n_q          <= '0;
      used_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;

      if (in_acc) begin
        op_q  <= action_e'(in_i.action);
        cnt_q <= '0;
        n_q   <= '0;
      end else if ((state_q == ST_SCAN) && !(scan_hit || last_slot)) begin
        cnt_q <= cnt_q + CW'(1);
      end else if ((state_q == ST_PROC) && !stall && !last_slot) begin
        cnt_q <= cnt_q + CW'(1);
      end

      // Output register: a loaded beat wins over a drained one
      if (((state_q == ST_SCAN) && (scan_hit || last_slot) && out_free) ||
          ((state_q == ST_PROC) && emit_go && held_valid_q && !stall) ||
          ((state_q == ST_FLUSH) && held_valid_q && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if ((state_q == ST_PROC) && emit_go && !stall) begin
        held_valid_q <= 1'b1;
        n_q          <= n_q + NW'(1);
      end else if ((state_q == ST_FLUSH) && out_free) begin
        held_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      handle_q <= in_i.task_handle;
      delay_q  <= in_i.delay_ticks;
      period_q <= in_i.period_ticks;
    end
    if ((state_q == ST_PROC) && emit_go && !stall) begin
      held_slot_q   <= cnt_q;
      held_handle_q <= rd_rec.handle;
    end
    case (state_q)
      ST_SCAN: begin
        if ((scan_hit || last_slot) && out_free) begin
          out_kind_q   <= KIND_ADD;
          out_slot_q   <= scan_hit ? cnt_q : CW'(NUM_SLOTS);
          out_handle_q <= 16'd0;
          out_last_q   <= 1'b1;
        end
      end
      ST_PROC: begin
        if (emit_go && held_valid_q && !stall) begin
          out_kind_q   <= KIND_RUN;
          out_slot_q   <= held_slot_q;
          out_handle_q <= held_handle_q;
          out_last_q   <= 1'b0;
        end
      end
      ST_FLUSH: begin
        if (held_valid_q && out_free) begin
          out_kind_q   <= KIND_RUN;
          out_slot_q   <= held_slot_q;
          out_handle_q <= held_handle_q;
          out_last_q   <= 1'b1;
        end
      end
      default: begin
        out_kind_q <= out_kind_q;
      end
    endcase
  end

  assign slot_wide         = (CW+5)'(out_slot_q);
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.slot_index  = slot_wide[4:0];
  assign out_o.run_handle  = out_handle_q;
  assign out_o.last_of_run = out_last_q;

  // An accepted add always starts the free-slot walk
  a_add_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == ACT_ADD)) |=> (state_q == ST_SCAN))
    else $error("add beat did not start the slot walk");

  // A dispatch never hands out more beats than the per-item limit
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q <= NW'(MAX_RESULTS)))
    else $error("dispatch beat count above limit");

  // The lookahead beat lives only inside a dispatch walk
  a_held_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> ((state_q == ST_READ) || (state_q == ST_PROC) ||
                      (state_q == ST_FLUSH)))
    else $error("held dispatch beat outside a dispatch");

  // A stalled walk keeps its slot pointer
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PROC) && stall) |=> ($stable(cnt_q) && (state_q == ST_PROC)))
    else $error("slot pointer moved during output stall");

endmodule
